// File: hw/rtl/cassette_pulse_block_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// Cassette pulse block decoder assertion macros
// Shared concurrent assertion forms used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef CASSETTE_PULSE_BLOCK_DECODER_CORE_ASSERT_SVH
`define CASSETTE_PULSE_BLOCK_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPBD_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("cpbd assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define CPBD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("cpbd assertion failed in the following cycle");

`endif

// File: hw/rtl/cpbd_pkg.sv
// ----------------------------------------------------------------------------
// Cassette pulse block decoder package
// Types and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package cpbd_pkg;

   localparam int unsigned LengthWidth = 15;
   localparam int unsigned TicksWidth  = 19;
   localparam int unsigned DelayWidth  = 10;
   localparam int unsigned TpuWidth    = 4;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDataWidth = 10;

   localparam logic [CsrIdxWidth-1:0] CSR_INVERT_PHASE   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RAW_BYTE_MODE  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SAMPLE_DELAY   = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_TICKS_PER_UNIT = 2'd3;

   localparam logic [DelayWidth-1:0] SAMPLE_DELAY_RESET = 10'd312;
   localparam logic [TpuWidth-1:0]   TICKS_PER_UNIT_RESET = 4'd9;

   localparam logic [3:0] FRAME_HUNT    = 4'd0;
   localparam logic [3:0] FRAME_LAST_DATA = 4'd8;
   localparam logic [3:0] FRAME_STOP1   = 4'd9;
   localparam logic [3:0] FRAME_STOP2   = 4'd10;

   localparam logic [7:0] MARK_HEAD = 8'h01;
   localparam logic [7:0] MARK_TAIL = 8'h3c;

   localparam logic [2:0] KIND_RAW_BYTE  = 3'd0;
   localparam logic [2:0] KIND_DATA_BYTE = 3'd1;
   localparam logic [2:0] KIND_BLOCK_OK  = 3'd2;
   localparam logic [2:0] KIND_CHECKSUM  = 3'd3;
   localparam logic [2:0] KIND_FRAMING   = 3'd4;

   typedef enum logic [1:0] {
      EDGE_WAIT_LOW  = 2'd0,
      EDGE_WAIT_HIGH = 2'd1,
      EDGE_COUNT     = 2'd2
   } edge_phase_type;

   typedef enum logic [2:0] {
      BLOCK_HUNT = 3'd0,
      BLOCK_TYPE = 3'd1,
      BLOCK_LEN  = 3'd2,
      BLOCK_DATA = 3'd3,
      BLOCK_SUM  = 3'd4
   } block_phase_type;

   typedef struct packed {
      logic                  invert_phase;
      logic                  raw_byte_mode;
      logic [DelayWidth-1:0] sample_delay;
      logic [TpuWidth-1:0]   ticks_per_unit;
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      logic                  level;
      logic [TicksWidth-1:0] ticks;
   } pulse_type;

   typedef struct packed {
      logic       byte_done;
      logic       frame_error;
      logic [7:0] byte_value;
   } frame_event_type;

   typedef struct packed {
      logic [2:0] result_kind;
      logic [7:0] byte_value;
      logic [7:0] block_type;
      logic [7:0] byte_index;
      logic [7:0] block_length;
   } result_type;

endpackage

// File: hw/rtl/cpbd_pulse_stage.sv
// ----------------------------------------------------------------------------
// Pulse input stage
// Registers an accepted request as a level and a tick count.
// ----------------------------------------------------------------------------
module cpbd_pulse_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  cpbd_pkg::cfg_type                   cfg,
   input  logic                                hold,
   input  logic                                req_valid,
   input  logic                                req_pulse_level,
   input  logic [cpbd_pkg::LengthWidth-1:0]    req_pulse_length,
   output cpbd_pkg::pulse_type                 pulse
);
   import cpbd_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  level_ff, level_in;
   logic [TicksWidth-1:0] ticks_ff, ticks_in;

   always_comb begin
      valid_in = valid_ff;
      level_in = level_ff;
      ticks_in = ticks_ff;
      if (!hold) begin
         valid_in = req_valid;
         level_in = req_pulse_level ^ cfg.invert_phase;
         ticks_in = TicksWidth'(req_pulse_length) * TicksWidth'(cfg.ticks_per_unit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      level_ff <= level_in;
      ticks_ff <= ticks_in;
   end

   assign pulse.valid = valid_ff;
   assign pulse.level = level_ff;
   assign pulse.ticks = ticks_ff;

endmodule

// File: hw/rtl/cpbd_bit_framer.sv
// ----------------------------------------------------------------------------
// Bit sampler and byte framer
// Finds rising edges in the tick stream, samples one bit per edge and
// assembles start, data and stop bits into framed bytes.
// ----------------------------------------------------------------------------
module cpbd_bit_framer (
   input  logic                        clock,
   input  logic                        reset,
   input  cpbd_pkg::cfg_type           cfg,
   input  logic                        fire,
   input  cpbd_pkg::pulse_type         pulse,
   output cpbd_pkg::frame_event_type   frame_event
);
   import cpbd_pkg::*;

   edge_phase_type        edge_phase_ff, edge_phase_in;
   logic [DelayWidth-1:0] delay_left_ff, delay_left_in;
   logic [3:0]            frame_pos_ff, frame_pos_in;
   logic [7:0]            shift_byte_ff, shift_byte_in;
   logic                  stop_bad_ff, stop_bad_in;

   logic                  count_en;
   logic [TicksWidth-1:0] count_ticks;
   logic [DelayWidth-1:0] count_delay;
   logic [TicksWidth-1:0] count_delay_ext;
   logic                  bit_got;
   logic                  bit_value;

   assign count_delay_ext = TicksWidth'(count_delay);

   always_comb begin
      edge_phase_in = edge_phase_ff;
      delay_left_in = delay_left_ff;
      count_en      = 1'b0;
      count_ticks   = pulse.ticks;
      count_delay   = delay_left_ff;
      bit_got       = 1'b0;
      bit_value     = 1'b0;
      if (fire && (pulse.ticks != '0)) begin
         unique case (edge_phase_ff)
            EDGE_WAIT_LOW: begin
               if (!pulse.level) begin
                  edge_phase_in = EDGE_WAIT_HIGH;
               end
            end
            EDGE_WAIT_HIGH: begin
               if (pulse.level) begin
                  if (cfg.sample_delay == '0) begin
                     bit_got       = 1'b1;
                     bit_value     = 1'b1;
                     edge_phase_in = EDGE_WAIT_LOW;
                  end else begin
                     count_en    = 1'b1;
                     count_ticks = pulse.ticks - TicksWidth'(1);
                     count_delay = cfg.sample_delay;
                  end
               end
            end
            EDGE_COUNT: begin
               count_en = 1'b1;
            end
            default: begin
               edge_phase_in = EDGE_WAIT_LOW;
            end
         endcase
         if (count_en) begin
            if (count_ticks >= count_delay_ext) begin
               bit_got       = 1'b1;
               bit_value     = pulse.level;
               delay_left_in = '0;
               if (!pulse.level && (count_ticks != count_delay_ext)) begin
                  edge_phase_in = EDGE_WAIT_HIGH;
               end else begin
                  edge_phase_in = EDGE_WAIT_LOW;
               end
            end else begin
               delay_left_in = count_delay - count_ticks[DelayWidth-1:0];
               edge_phase_in = EDGE_COUNT;
            end
         end
      end
   end

   always_comb begin
      frame_pos_in  = frame_pos_ff;
      shift_byte_in = shift_byte_ff;
      stop_bad_in   = stop_bad_ff;
      frame_event.byte_done   = 1'b0;
      frame_event.frame_error = 1'b0;
      frame_event.byte_value  = shift_byte_ff;
      if (bit_got) begin
         priority if (frame_pos_ff == FRAME_HUNT) begin
            if (!bit_value) begin
               frame_pos_in = frame_pos_ff + 4'd1;
            end
         end else if (frame_pos_ff <= FRAME_LAST_DATA) begin
            shift_byte_in = {bit_value, shift_byte_ff[7:1]};
            frame_pos_in  = frame_pos_ff + 4'd1;
         end else if (frame_pos_ff == FRAME_STOP1) begin
            stop_bad_in  = !bit_value;
            frame_pos_in = FRAME_STOP2;
         end else begin
            frame_pos_in = FRAME_HUNT;
            if (stop_bad_ff || !bit_value) begin
               stop_bad_in             = 1'b0;
               frame_event.frame_error = 1'b1;
            end else begin
               frame_event.byte_done = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_phase_ff <= EDGE_WAIT_LOW;
         delay_left_ff <= '0;
         frame_pos_ff  <= FRAME_HUNT;
         shift_byte_ff <= '0;
         stop_bad_ff   <= 1'b0;
      end else begin
         edge_phase_ff <= edge_phase_in;
         delay_left_ff <= delay_left_in;
         frame_pos_ff  <= frame_pos_in;
         shift_byte_ff <= shift_byte_in;
         stop_bad_ff   <= stop_bad_in;
      end
   end

endmodule

// File: hw/rtl/cpbd_block_parser.sv
// ----------------------------------------------------------------------------
// Block parser
// Hunts for the block marker and walks type, length, payload and checksum,
// turning framed bytes into results.
// ----------------------------------------------------------------------------
module cpbd_block_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        raw_byte_mode,
   input  cpbd_pkg::frame_event_type   frame_event,
   output logic                        result_valid,
   output cpbd_pkg::result_type        result
);
   import cpbd_pkg::*;

   block_phase_type block_phase_ff, block_phase_in;
   logic            mark_head_ff, mark_head_in;
   logic [7:0]      cur_type_ff, cur_type_in;
   logic [7:0]      decl_len_ff, decl_len_in;
   logic [7:0]      taken_ff, taken_in;
   logic [7:0]      sum_ff, sum_in;
   logic [7:0]      taken_next;
   logic [7:0]      in_byte;

   assign in_byte    = frame_event.byte_value;
   assign taken_next = taken_ff + 8'd1;

   always_comb begin
      block_phase_in = block_phase_ff;
      mark_head_in   = mark_head_ff;
      cur_type_in    = cur_type_ff;
      decl_len_in    = decl_len_ff;
      taken_in       = taken_ff;
      sum_in         = sum_ff;
      if (frame_event.frame_error) begin
         if (!raw_byte_mode) begin
            block_phase_in = BLOCK_HUNT;
            mark_head_in   = 1'b0;
         end
      end else if (frame_event.byte_done && !raw_byte_mode) begin
         unique case (block_phase_ff)
            BLOCK_HUNT: begin
               if (mark_head_ff && (in_byte == MARK_TAIL)) begin
                  block_phase_in = BLOCK_TYPE;
                  mark_head_in   = 1'b0;
               end else begin
                  mark_head_in = (in_byte == MARK_HEAD);
               end
            end
            BLOCK_TYPE: begin
               cur_type_in    = in_byte;
               block_phase_in = BLOCK_LEN;
            end
            BLOCK_LEN: begin
               decl_len_in    = in_byte;
               sum_in         = cur_type_ff + in_byte;
               taken_in       = '0;
               block_phase_in = (in_byte == '0) ? BLOCK_SUM : BLOCK_DATA;
            end
            BLOCK_DATA: begin
               sum_in   = sum_ff + in_byte;
               taken_in = taken_next;
               if (taken_next == decl_len_ff) begin
                  block_phase_in = BLOCK_SUM;
               end
            end
            BLOCK_SUM: begin
               block_phase_in = BLOCK_HUNT;
               mark_head_in   = 1'b0;
            end
            default: begin
               block_phase_in = BLOCK_HUNT;
               mark_head_in   = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      result_valid = 1'b0;
      result       = '0;
      if (frame_event.frame_error) begin
         result_valid       = 1'b1;
         result.result_kind = KIND_FRAMING;
      end else if (frame_event.byte_done) begin
         if (raw_byte_mode) begin
            result_valid       = 1'b1;
            result.result_kind = KIND_RAW_BYTE;
            result.byte_value  = in_byte;
         end else if (block_phase_ff == BLOCK_DATA) begin
            result_valid        = 1'b1;
            result.result_kind  = KIND_DATA_BYTE;
            result.byte_value   = in_byte;
            result.block_type   = cur_type_ff;
            result.byte_index   = taken_ff;
            result.block_length = decl_len_ff;
         end else if (block_phase_ff == BLOCK_SUM) begin
            result_valid        = 1'b1;
            result.result_kind  = (in_byte == sum_ff) ? KIND_BLOCK_OK : KIND_CHECKSUM;
            result.block_type   = cur_type_ff;
            result.block_length = decl_len_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_phase_ff <= BLOCK_HUNT;
         mark_head_ff   <= 1'b0;
         cur_type_ff    <= '0;
         decl_len_ff    <= '0;
         taken_ff       <= '0;
         sum_ff         <= '0;
      end else begin
         block_phase_ff <= block_phase_in;
         mark_head_ff   <= mark_head_in;
         cur_type_ff    <= cur_type_in;
         decl_len_ff    <= decl_len_in;
         taken_ff       <= taken_in;
         sum_ff         <= sum_in;
      end
   end

endmodule

// File: hw/rtl/cassette_pulse_block_decoder_core.sv
// Path: an accepted request is registered in the input register, decoded
// combinationally by the framer and parser, and captured in the result register.
// Throughput: one request per cycle while the result register is not stalled.
// A stalled result holds the result register and, with a pulse pending, the input register.
// Reset is synchronous and active high; it clears the valid flags and the
// decoder state and reloads the register defaults.
// ----------------------------------------------------------------------------
// Cassette pulse block decoder core
// Decodes tape pulse words into framed bytes and block results.
// ----------------------------------------------------------------------------
`include "cassette_pulse_block_decoder_core_assert.svh"

module cassette_pulse_block_decoder_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [cpbd_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [cpbd_pkg::CsrDataWidth-1:0]    csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_pulse_level,
   input  logic [cpbd_pkg::LengthWidth-1:0]     req_pulse_length,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_result_kind,
   output logic [7:0]                           rsp_byte_value,
   output logic [7:0]                           rsp_block_type,
   output logic [7:0]                           rsp_byte_index,
   output logic [7:0]                           rsp_block_length
);
   import cpbd_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   pulse_type       pulse;
   frame_event_type frame_event;
   logic            out_free;
   logic            fire;
   logic            res_valid;
   result_type      res;
   logic            rsp_valid_ff, rsp_valid_in;
   result_type      rsp_ff, rsp_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INVERT_PHASE:   cfg_in.invert_phase   = csr_write_data[0];
            CSR_RAW_BYTE_MODE:  cfg_in.raw_byte_mode  = csr_write_data[0];
            CSR_SAMPLE_DELAY:   cfg_in.sample_delay   = csr_write_data[DelayWidth-1:0];
            CSR_TICKS_PER_UNIT: cfg_in.ticks_per_unit = csr_write_data[TpuWidth-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = pulse.valid && out_free;
   assign req_stall = pulse.valid && !out_free;

   cpbd_pulse_stage u_pulse_stage (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .hold             (req_stall),
      .req_valid        (req_valid),
      .req_pulse_level  (req_pulse_level),
      .req_pulse_length (req_pulse_length),
      .pulse            (pulse)
   );

   cpbd_bit_framer u_bit_framer (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .fire        (fire),
      .pulse       (pulse),
      .frame_event (frame_event)
   );

   cpbd_block_parser u_block_parser (
      .clock         (clock),
      .reset         (reset),
      .raw_byte_mode (cfg_ff.raw_byte_mode),
      .frame_event   (frame_event),
      .result_valid  (res_valid),
      .result        (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = fire && res_valid;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.invert_phase   <= 1'b0;
         cfg_ff.raw_byte_mode  <= 1'b0;
         cfg_ff.sample_delay   <= SAMPLE_DELAY_RESET;
         cfg_ff.ticks_per_unit <= TICKS_PER_UNIT_RESET;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_ff.result_kind;
   assign rsp_byte_value   = rsp_ff.byte_value;
   assign rsp_block_type   = rsp_ff.block_type;
   assign rsp_byte_index   = rsp_ff.byte_index;
   assign rsp_block_length = rsp_ff.block_length;

   `CPBD_ASSERT_SAME(a_data_index_in_block, clock, reset,
      rsp_valid_ff && (rsp_ff.result_kind == KIND_DATA_BYTE),
      rsp_ff.byte_index < rsp_ff.block_length)
   `CPBD_ASSERT_SAME(a_status_has_no_byte, clock, reset,
      rsp_valid_ff && (rsp_ff.result_kind != KIND_DATA_BYTE) &&
      (rsp_ff.result_kind != KIND_RAW_BYTE),
      rsp_ff.byte_value == '0)
   `CPBD_ASSERT_SAME(a_framing_has_no_block, clock, reset,
      rsp_valid_ff && (rsp_ff.result_kind == KIND_FRAMING),
      (rsp_ff.block_type == '0) && (rsp_ff.block_length == '0) &&
      (rsp_ff.byte_index == '0))
   `CPBD_ASSERT_NEXT(a_stall_keeps_request, clock, reset,
      req_stall,
      pulse.valid)

endmodule

// File: verif/tb_cassette_pulse_block_decoder_core.sv
// ----------------------------------------------------------------------------
// Cassette pulse block decoder core testbench
// Feeds tape pulse words built from framed bytes, marker-led blocks, broken
// frames and line noise, under changing register settings and random idling
// on both channels. An in-bench decoder predicts every result, and each
// result that leaves the core is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_cassette_pulse_block_decoder_core;
   import cpbd_pkg::*;

   localparam int WatchdogLimit = 4000;
   localparam logic [1:0] STOPS_OK = 2'b11;

   typedef struct packed {
      logic                   level;
      logic [LengthWidth-1:0] length;
   } tape_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = CSR_INVERT_PHASE;
   logic [CsrDataWidth-1:0] csr_write_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_pulse_level = 1'b0;
   logic [LengthWidth-1:0]  req_pulse_length = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [2:0]              rsp_result_kind;
   logic [7:0]              rsp_byte_value;
   logic [7:0]              rsp_block_type;
   logic [7:0]              rsp_byte_index;
   logic [7:0]              rsp_block_length;

   cassette_pulse_block_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pulse_level  (req_pulse_level),
      .req_pulse_length (req_pulse_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_block_type   (rsp_block_type),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_block_length (rsp_block_length)
   );

   always #5 clock = ~clock;

   tape_word_type   tape_words[$];
   result_type      pending_decodes[$];
   int              words_made = 0;
   int              results_meant = 0;
   int              fault_count = 0;
   int              req_gap_pct = 0;
   int              rsp_hold_pct = 0;
   int              gap_left = 0;
   int              hold_left = 0;
   int              idle_cycles = 0;

   cfg_type         cfg = '{1'b0, 1'b0, SAMPLE_DELAY_RESET, TICKS_PER_UNIT_RESET};
   edge_phase_type  edge_st = EDGE_WAIT_LOW;
   logic [9:0]      wait_ticks = '0;
   logic [3:0]      frame_pos = FRAME_HUNT;
   logic [7:0]      shifter = '0;
   logic            stop_bad = 1'b0;
   block_phase_type blk_st = BLOCK_HUNT;
   logic            saw_head = 1'b0;
   logic [7:0]      blk_type = '0;
   logic [7:0]      blk_len = '0;
   logic [7:0]      blk_count = '0;
   logic [7:0]      blk_sum = '0;

   function automatic bit sample_bit(input logic lv, input int unsigned ticks, output logic b);
      int unsigned t;
      t = ticks;
      b = 1'b0;
      if (t == 0) return 1'b0;
      if (edge_st == EDGE_WAIT_LOW) begin
         if (!lv) edge_st = EDGE_WAIT_HIGH;
         return 1'b0;
      end
      if (edge_st == EDGE_WAIT_HIGH) begin
         if (!lv) return 1'b0;
         t = t - 1;
         if (cfg.sample_delay == 0) begin
            b = 1'b1;
            edge_st = EDGE_WAIT_LOW;
            return 1'b1;
         end
         wait_ticks = cfg.sample_delay;
         edge_st = EDGE_COUNT;
      end
      if (t >= wait_ticks) begin
         t = t - wait_ticks;
         wait_ticks = '0;
         b = lv;
         edge_st = (!lv && t > 0) ? EDGE_WAIT_HIGH : EDGE_WAIT_LOW;
         return 1'b1;
      end
      wait_ticks = 10'(wait_ticks - t);
      return 1'b0;
   endfunction

   function automatic bit block_byte(input logic [7:0] v, output result_type r);
      r = '0;
      if (cfg.raw_byte_mode) begin
         r.result_kind = KIND_RAW_BYTE;
         r.byte_value = v;
         return 1'b1;
      end
      case (blk_st)
         BLOCK_HUNT: begin
            if (saw_head && v == MARK_TAIL) begin
               blk_st = BLOCK_TYPE;
               saw_head = 1'b0;
            end else begin
               saw_head = (v == MARK_HEAD);
            end
            return 1'b0;
         end
         BLOCK_TYPE: begin
            blk_type = v;
            blk_st = BLOCK_LEN;
            return 1'b0;
         end
         BLOCK_LEN: begin
            blk_len = v;
            blk_sum = blk_type + v;
            blk_count = '0;
            blk_st = (v == 8'd0) ? BLOCK_SUM : BLOCK_DATA;
            return 1'b0;
         end
         BLOCK_DATA: begin
            r.result_kind = KIND_DATA_BYTE;
            r.byte_value = v;
            r.block_type = blk_type;
            r.byte_index = blk_count;
            r.block_length = blk_len;
            blk_sum = blk_sum + v;
            blk_count = blk_count + 8'd1;
            if (blk_count == blk_len) blk_st = BLOCK_SUM;
            return 1'b1;
         end
         default: begin
            r.result_kind = (v == blk_sum) ? KIND_BLOCK_OK : KIND_CHECKSUM;
            r.block_type = blk_type;
            r.block_length = blk_len;
            blk_st = BLOCK_HUNT;
            saw_head = 1'b0;
            return 1'b1;
         end
      endcase
   endfunction

   function automatic bit frame_bit(input logic b, output result_type r);
      r = '0;
      if (frame_pos == FRAME_HUNT) begin
         if (!b) frame_pos = frame_pos + 4'd1;
         return 1'b0;
      end
      if (frame_pos <= FRAME_LAST_DATA) begin
         shifter = {b, shifter[7:1]};
         frame_pos = frame_pos + 4'd1;
         return 1'b0;
      end
      if (frame_pos == FRAME_STOP1) begin
         stop_bad = ~b;
         frame_pos = FRAME_STOP2;
         return 1'b0;
      end
      frame_pos = FRAME_HUNT;
      if (stop_bad || !b) begin
         stop_bad = 1'b0;
         if (!cfg.raw_byte_mode) begin
            blk_st = BLOCK_HUNT;
            saw_head = 1'b0;
         end
         r.result_kind = KIND_FRAMING;
         return 1'b1;
      end
      return block_byte(shifter, r);
   endfunction

   function automatic bit decode_word(input logic level, input logic [LengthWidth-1:0] length,
                                      output result_type r);
      logic b;
      int unsigned t;
      r = '0;
      t = 32'(length) * 32'(cfg.ticks_per_unit);
      if (!sample_bit(level ^ cfg.invert_phase, t, b)) return 1'b0;
      return frame_bit(b, r);
   endfunction

   task automatic add_word(input logic level, input logic [LengthWidth-1:0] length);
      tape_words.push_back('{level ^ cfg.invert_phase, length});
      words_made++;
   endtask

   task automatic add_segment(input logic level, input int units);
      int part;
      if (units > 32767) units = 32767;
      if ($urandom_range(0, 15) == 0) add_word(1'($urandom_range(0, 1)), '0);
      if (units >= 2 && $urandom_range(0, 7) == 0) begin
         part = $urandom_range(1, units - 1);
         add_word(level, LengthWidth'(part));
         add_word(level, LengthWidth'(units - part));
      end else begin
         add_word(level, LengthWidth'(units));
      end
   endtask

   task automatic add_bit(input logic b);
      int tpu, dly, hi, lo;
      tpu = int'(cfg.ticks_per_unit);
      dly = int'(cfg.sample_delay);
      if (b) begin
         hi = (dly + tpu) / tpu + $urandom_range(0, 2);
         lo = $urandom_range(1, 3);
      end else begin
         hi = $urandom_range(1, dly / tpu);
         lo = (dly - hi * tpu + 1 + tpu) / tpu + $urandom_range(0, 2);
      end
      add_segment(1'b1, hi);
      add_segment(1'b0, lo);
   endtask

   task automatic add_byte(input logic [7:0] v, input logic [1:0] stops);
      repeat ($urandom_range(0, 1)) add_bit(1'b1);
      add_bit(1'b0);
      for (int i = 0; i < 8; i++) add_bit(v[i]);
      add_bit(stops[0]);
      add_bit(stops[1]);
      if (cfg.raw_byte_mode || stops != STOPS_OK) results_meant++;
   endtask

   // A long low settles any pending sample, and eleven ones close any open frame.
   task automatic resync();
      add_segment(1'b0, 1030 / int'(cfg.ticks_per_unit) + 2);
      repeat (11) add_bit(1'b1);
   endtask

   task automatic add_block(input logic [7:0] type_byte, input int count, input bit good);
      logic [7:0] sum, d;
      add_byte(MARK_HEAD, STOPS_OK);
      if ($urandom_range(0, 3) == 0) add_byte(MARK_HEAD, STOPS_OK);
      add_byte(MARK_TAIL, STOPS_OK);
      add_byte(type_byte, STOPS_OK);
      add_byte(count[7:0], STOPS_OK);
      sum = type_byte + count[7:0];
      repeat (count) begin
         d = 8'($urandom_range(0, 255));
         sum = sum + d;
         add_byte(d, STOPS_OK);
      end
      if (!good) sum = sum ^ 8'($urandom_range(1, 255));
      add_byte(sum, STOPS_OK);
      if (!cfg.raw_byte_mode) results_meant += count + 1;
   endtask

   task automatic random_traffic(input int budget);
      int stop_at, pick, count, taken;
      stop_at = words_made + budget;
      while (words_made < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 4);
            add_block(8'($urandom_range(0, 255)), count, $urandom_range(0, 4) != 0);
         end else if (pick < 72) begin
            add_byte(8'($urandom_range(0, 255)), STOPS_OK);
         end else if (pick < 84) begin
            count = $urandom_range(1, 255);
            taken = $urandom_range(0, (count < 4) ? count - 1 : 3);
            add_byte(MARK_HEAD, STOPS_OK);
            add_byte(MARK_TAIL, STOPS_OK);
            add_byte(8'($urandom_range(0, 255)), STOPS_OK);
            add_byte(count[7:0], STOPS_OK);
            repeat (taken) add_byte(8'($urandom_range(0, 255)), STOPS_OK);
            add_byte(8'($urandom_range(0, 255)), 2'($urandom_range(0, 2)));
            if (!cfg.raw_byte_mode) results_meant += taken;
         end else if (pick < 92) begin
            add_byte(8'($urandom_range(0, 255)), 2'($urandom_range(0, 2)));
         end else begin
            repeat ($urandom_range(1, 4))
               add_word(1'($urandom_range(0, 1)), LengthWidth'($urandom_range(0, 32767)));
            resync();
         end
      end
   endtask

   task automatic drain();
      while (tape_words.size() != 0 || req_valid || pending_decodes.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_INVERT_PHASE:   cfg.invert_phase = data[0];
         CSR_RAW_BYTE_MODE:  cfg.raw_byte_mode = data[0];
         CSR_SAMPLE_DELAY:   cfg.sample_delay = data[DelayWidth-1:0];
         CSR_TICKS_PER_UNIT: cfg.ticks_per_unit = data[TpuWidth-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic begin_phase(input bit inv, input bit raw, input int delay, input int tpu);
      drain();
      write_reg(CSR_INVERT_PHASE, CsrDataWidth'(inv));
      write_reg(CSR_RAW_BYTE_MODE, CsrDataWidth'(raw));
      write_reg(CSR_SAMPLE_DELAY, CsrDataWidth'(delay));
      write_reg(CSR_TICKS_PER_UNIT, CsrDataWidth'(tpu));
      csr_write_enable <= 1'b0;
      req_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 30);
      rsp_hold_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 20);
   endtask

   task automatic log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%t: %s", $time, msg);
   endtask

   always @(posedge clock) begin : driver
      result_type    r;
      tape_word_type w;
      logic          take;
      take = !reset && req_valid && !req_stall;
      if (take && decode_word(req_pulse_level, req_pulse_length, r)) pending_decodes.push_back(r);
      if (req_valid && !take) begin
         req_valid <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (tape_words.size() != 0 && req_gap_pct != 0 &&
                   $urandom_range(0, 99) < req_gap_pct) begin
         gap_left = $urandom_range(0, 15);
         req_valid <= 1'b0;
      end else if (tape_words.size() != 0) begin
         w = tape_words.pop_front();
         req_valid <= 1'b1;
         req_pulse_level <= w.level;
         req_pulse_length <= w.length;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(posedge clock) begin : monitor
      result_type want, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_result_kind, rsp_byte_value, rsp_block_type, rsp_byte_index,
                 rsp_block_length};
         if (pending_decodes.size() == 0) begin
            log_fault($sformatf("unexpected result kind %0d value %02h", got.result_kind,
                                got.byte_value));
         end else begin
            want = pending_decodes.pop_front();
            if (got.result_kind !== want.result_kind || got.byte_value !== want.byte_value ||
                got.block_type !== want.block_type || got.byte_index !== want.byte_index ||
                got.block_length !== want.block_length)
               log_fault($sformatf(
                  "kind %0d/%0d byte %02h/%02h type %02h/%02h idx %0d/%0d len %0d/%0d exp/act",
                  want.result_kind, got.result_kind, want.byte_value, got.byte_value,
                  want.block_type, got.block_type, want.byte_index, got.byte_index,
                  want.block_length, got.block_length));
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_hold_pct != 0 && $urandom_range(0, 99) < rsp_hold_pct) begin
         hold_left = $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
         $display("tb_cassette_pulse_block_decoder_core: errors");
         $finish;
      end
   end

   initial begin : stimulus
      int tpu, dly;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      begin_phase(1'b0, 1'b0, int'(SAMPLE_DELAY_RESET), int'(TICKS_PER_UNIT_RESET));
      add_word(1'b1, 15'd32767);
      add_word(1'b0, 15'd0);
      add_word(1'b0, 15'd32767);
      add_word(1'b1, 15'd0);
      add_word(1'b1, 15'd1);
      add_word(1'b0, 15'd32767);
      add_word(1'b1, 15'd32767);
      add_word(1'b0, 15'd1);

      begin_phase(1'b0, 1'b0, int'(SAMPLE_DELAY_RESET), 0);
      add_word(1'b0, 15'd5);
      add_word(1'b1, 15'd5);
      add_word(1'b0, 15'd32767);
      add_word(1'b1, 15'd32767);

      begin_phase(1'b0, 1'b0, 0, int'(TICKS_PER_UNIT_RESET));
      repeat (4) begin
         add_word(1'b0, LengthWidth'($urandom_range(1, 3)));
         add_word(1'b1, LengthWidth'($urandom_range(1, 3)));
      end

      begin_phase(1'b0, 1'b0, int'(SAMPLE_DELAY_RESET), int'(TICKS_PER_UNIT_RESET));
      resync();
      add_block(8'($urandom_range(0, 255)), 0, 1'b1);
      add_block(8'hff, 2, 1'b0);
      add_byte(8'($urandom_range(0, 255)), 2'b10);
      add_byte(8'($urandom_range(0, 255)), 2'b01);

      begin_phase(1'b1, 1'b0, 1023, 15);
      resync();
      random_traffic(40);

      begin_phase(1'b0, 1'b1, 1, 1);
      resync();
      random_traffic(40);

      // A block is opened in block mode, interrupted by a raw byte, then finished.
      begin_phase(1'b1, 1'b0, 64, 4);
      resync();
      add_byte(MARK_HEAD, STOPS_OK);
      add_byte(MARK_TAIL, STOPS_OK);
      add_byte(8'h7e, STOPS_OK);
      drain();
      write_reg(CSR_RAW_BYTE_MODE, CsrDataWidth'(1));
      csr_write_enable <= 1'b0;
      add_byte(8'($urandom_range(0, 255)), STOPS_OK);
      drain();
      write_reg(CSR_RAW_BYTE_MODE, CsrDataWidth'(0));
      csr_write_enable <= 1'b0;
      add_byte(8'd2, STOPS_OK);
      add_byte(8'h10, STOPS_OK);
      add_byte(8'h20, STOPS_OK);
      add_byte(8'hb0, STOPS_OK);
      results_meant += 3;

      while (words_made < 900 || results_meant < 12) begin
         tpu = $urandom_range(1, 15);
         dly = ($urandom_range(0, 3) == 0) ? $urandom_range(tpu, 1023)
                                           : $urandom_range(tpu, 120);
         begin_phase(1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0, dly, tpu);
         resync();
         random_traffic(40);
         if ($urandom_range(0, 1) == 0) add_segment(1'b1, 1);
      end

      tpu = $urandom_range(1, 15);
      begin_phase(1'($urandom_range(0, 1)), 1'b0, $urandom_range(tpu, 200), tpu);
      req_gap_pct = 0;
      rsp_hold_pct = 0;
      gap_left = 0;
      hold_left = 0;
      resync();
      random_traffic(40);

      drain();
      repeat (4) @(posedge clock);
      if (fault_count == 0 && pending_decodes.size() == 0)
         $display("tb_cassette_pulse_block_decoder_core: clean");
      else
         $display("tb_cassette_pulse_block_decoder_core: errors");
      $finish;
   end

endmodule
